/* rtl/bpm_pkg.sv */
// ----------------------------------------------------------------------------
// bpm_pkg: shared types and codes for the debug breakpoint matcher
// Request and response payloads, command and list codes, the sequencer state
// type and the control bundle that drives the breakpoint lists during a scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpm_pkg;

    // Widest list index needed for any supported list depth (up to 256).
    localparam int MAX_IDX_W = 8;

    localparam logic [2:0] CMD_CHECK     = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_RUN       = 3'd3;
    localparam logic [2:0] CMD_HALT      = 3'd4;
    localparam logic [2:0] CMD_SET_COUNT = 3'd5;
    localparam logic [2:0] CMD_LOAD      = 3'd6;

    localparam logic [1:0] SEL_CODE  = 2'd0;
    localparam logic [1:0] SEL_WRITE = 2'd1;
    localparam logic [1:0] SEL_READ  = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_CODE  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  list_select;
        logic [5:0]  entry_index;
        logic [15:0] entry_count;
        logic [23:0] entry_address;
        logic [23:0] program_counter;
        logic [23:0] last_write_address;
        logic [23:0] last_read_address;
    } bpm_req_t;

    typedef struct packed {
        logic       debug_halted;
        logic       hit;
        logic [1:0] hit_kind;
    } bpm_rsp_t;

    typedef struct packed {
        logic                 clear;
        logic                 rd_en;
        logic [MAX_IDX_W-1:0] rd_idx;
    } bpm_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } bpm_state_t;

endpackage

/* rtl/bpm_list.sv */
// ----------------------------------------------------------------------------
// bpm_list: one breakpoint list with its active count and comparator
// Holds the list memory, takes load and count commands for this list and any
// stop, and compares one entry per cycle against the latched check address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpm_list #(
    parameter int         LIST_DEPTH   = 64,
    parameter int         ADDRESS_BITS = 24,
    parameter logic [1:0] LIST_SEL     = 2'd0,
    localparam int        IDX_W        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    localparam int        CNT_W        = $clog2(LIST_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_fire,
    input  bpm_pkg::bpm_req_t   req_data,
    input  bpm_pkg::bpm_ctrl_t  ctrl,
    output logic [CNT_W-1:0]    count,
    output logic                found
);
    import bpm_pkg::*;

    logic [ADDRESS_BITS-1:0] table_mem [LIST_DEPTH];
    logic [ADDRESS_BITS-1:0] rd_data_reg;
    logic [ADDRESS_BITS-1:0] chk_addr_reg;
    logic [MAX_IDX_W-1:0]    rd_idx_reg;
    logic                    rd_valid_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    found_reg, found_next;

    logic [23:0]             chk_src;
    logic [31:0]             chk_addr_ext;
    logic [31:0]             entry_addr_ext;
    logic [MAX_IDX_W-1:0]    entry_idx_ext;
    logic [CNT_W-1:0]        sat_count;
    logic                    load_en;

    always_comb
    begin
        unique case (LIST_SEL)
            SEL_CODE:  chk_src = req_data.program_counter;
            SEL_WRITE: chk_src = req_data.last_write_address;
            default:   chk_src = req_data.last_read_address;
        endcase
    end

    assign chk_addr_ext   = 32'(chk_src);
    assign entry_addr_ext = 32'(req_data.entry_address);
    assign entry_idx_ext  = MAX_IDX_W'(req_data.entry_index);

    assign load_en = req_fire && (req_data.command == CMD_LOAD)
                     && (req_data.list_select == LIST_SEL)
                     && (9'(req_data.entry_index) < 9'(LIST_DEPTH));

    assign sat_count = (req_data.entry_count > 16'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH)
                                                                : CNT_W'(req_data.entry_count);

    always_comb
    begin
        priority if (req_fire && (req_data.command == CMD_STOP))
        begin
            count_next = '0;
        end
        else if (req_fire && (req_data.command == CMD_SET_COUNT)
                 && (req_data.list_select == LIST_SEL))
        begin
            count_next = sat_count;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Entries beyond this list's count may still be read while a longer list
    // is scanned; the index compare keeps them out of the result.
    always_comb
    begin
        priority if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (rd_valid_reg && (9'(rd_idx_reg) < 9'(count_reg))
                 && (rd_data_reg == chk_addr_reg))
        begin
            found_next = 1'b1;
        end
        else
        begin
            found_next = found_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            table_mem[entry_idx_ext[IDX_W-1:0]] <= entry_addr_ext[ADDRESS_BITS-1:0];
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= table_mem[ctrl.rd_idx[IDX_W-1:0]];
        end
        rd_idx_reg <= ctrl.rd_idx;
        if (req_fire)
        begin
            chk_addr_reg <= chk_addr_ext[ADDRESS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            found_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            found_reg    <= found_next;
            rd_valid_reg <= ctrl.rd_en;
        end
    end

    assign count = count_reg;
    assign found = found_reg;

endmodule

/* rtl/bpm_seq.sv */
// ----------------------------------------------------------------------------
// bpm_seq: scan sequencer, halt flag and response register
// Steps the shared read index across the lists, resolves the hit priority,
// keeps the sticky halted flag and holds the response until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpm_seq #(
    parameter int  LIST_DEPTH = 64,
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [2:0]          command,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bpm_pkg::bpm_rsp_t   rsp_data,
    input  logic [CNT_W-1:0]    code_count,
    input  logic [CNT_W-1:0]    write_count,
    input  logic [CNT_W-1:0]    read_count,
    input  logic [2:0]          found,
    output bpm_pkg::bpm_ctrl_t  ctrl
);
    import bpm_pkg::*;

    bpm_state_t       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             halted_reg, halted_next;
    logic             rsp_valid_reg, rsp_valid_next;
    bpm_rsp_t         rsp_data_reg, rsp_data_next;

    logic             req_fire;
    logic             done_take;
    logic [CNT_W-1:0] max_a, max_all;
    logic [1:0]       kind;

    assign req_fire = req_valid && req_ready;
    assign max_a    = (code_count > write_count) ? code_count : write_count;
    assign max_all  = (max_a > read_count) ? max_a : read_count;

    always_comb
    begin
        priority if (found[0])
        begin
            kind = KIND_CODE;
        end
        else if (found[1])
        begin
            kind = KIND_WRITE;
        end
        else if (found[2])
        begin
            kind = KIND_READ;
        end
        else
        begin
            kind = KIND_NONE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if ((command == CMD_CHECK) && !halted_reg && (max_all != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == (len_reg - CNT_W'(1)))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = (state_reg == ST_IDLE);
        done_take   = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);
        ctrl.clear  = req_fire;
        ctrl.rd_en  = (state_reg == ST_SCAN);
        ctrl.rd_idx = MAX_IDX_W'(idx_reg);
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (req_fire)
        begin
            idx_next = '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        len_next = req_fire ? max_all : len_reg;
    end

    always_comb
    begin
        halted_next = halted_reg;
        if (req_fire)
        begin
            unique case (command)
                CMD_START, CMD_HALT: halted_next = 1'b1;
                CMD_RUN, CMD_STOP:   halted_next = 1'b0;
                default:             halted_next = halted_reg;
            endcase
        end
        else if (done_take && (kind != KIND_NONE))
        begin
            halted_next = 1'b1;
        end
    end

    always_comb
    begin
        rsp_data_next = rsp_data_reg;
        if (done_take)
        begin
            rsp_data_next.debug_halted = halted_reg || (kind != KIND_NONE);
            rsp_data_next.hit          = (kind != KIND_NONE);
            rsp_data_next.hit_kind     = kind;
        end
        rsp_valid_next = done_take || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            halted_reg    <= halted_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        len_reg      <= len_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // The read index must stay inside the scan length taken at request time.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg < len_reg))
        else $error("scan index ran past the scan length");

    // A finished result is held while the receiver stalls.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && rsp_valid_reg && !rsp_ready) |=> (state_reg == ST_DONE))
        else $error("sequencer left DONE while the response was stalled");

    // A check while halted must not start a scan.
    a_no_scan_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (command == CMD_CHECK) && halted_reg) |=> (state_reg == ST_DONE))
        else $error("scan started while halted");

    // Any reported hit leaves the unit halted.
    a_hit_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (done_take && (kind != KIND_NONE)) |=> halted_reg)
        else $error("hit did not set the halted flag");

endmodule

/* rtl/debug_breakpoint_matcher_core.sv */
// ----------------------------------------------------------------------------
// debug_breakpoint_matcher_core: hardware breakpoint comparator
// Three breakpoint lists (code, data write, data read) scanned in parallel
// against a check request, with a sticky halted flag.
// ----------------------------------------------------------------------------
// Usage: each request on the req channel (valid/ready) carries a command and
// its operands; every request produces exactly one response on the rsp
// channel (valid/ready) with the halted flag and, for a check, the hit kind.
// A check while running reads the three list memories in parallel, one entry
// per cycle, for as many entries as the longest active list holds; the
// sequencer then passes through a flush state and a done state, and the
// response is registered as it leaves done. Every other command, a check while
// halted and a check with every list empty go from idle straight to the done
// state without a scan. The sequencer handles one request at a time:
// req_ready is high only while it is idle, so a new request is taken only
// once the last one has left the done state. The response sits in an output
// register; a stalled receiver holds it there, and the next request only
// finishes once that response has been taken.
// After reset the halted flag and all three counts are zero; list contents
// are undefined until loaded, and no clearing pass is run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debug_breakpoint_matcher_core #(
    parameter int LIST_DEPTH   = 64,
    parameter int ADDRESS_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  bpm_pkg::bpm_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output bpm_pkg::bpm_rsp_t rsp_data
);
    import bpm_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    bpm_ctrl_t        ctrl;
    logic             req_fire;
    logic [CNT_W-1:0] code_count, write_count, read_count;
    logic [2:0]       found;

    assign req_fire = req_valid && req_ready;

    bpm_seq #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .command     (req_data.command),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_data    (rsp_data),
        .code_count  (code_count),
        .write_count (write_count),
        .read_count  (read_count),
        .found       (found),
        .ctrl        (ctrl)
    );

    bpm_list #(
        .LIST_DEPTH   (LIST_DEPTH),
        .ADDRESS_BITS (ADDRESS_BITS),
        .LIST_SEL     (SEL_CODE)
    ) u_code_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .req_data (req_data),
        .ctrl     (ctrl),
        .count    (code_count),
        .found    (found[0])
    );

    bpm_list #(
        .LIST_DEPTH   (LIST_DEPTH),
        .ADDRESS_BITS (ADDRESS_BITS),
        .LIST_SEL     (SEL_WRITE)
    ) u_write_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .req_data (req_data),
        .ctrl     (ctrl),
        .count    (write_count),
        .found    (found[1])
    );

    bpm_list #(
        .LIST_DEPTH   (LIST_DEPTH),
        .ADDRESS_BITS (ADDRESS_BITS),
        .LIST_SEL     (SEL_READ)
    ) u_read_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_fire (req_fire),
        .req_data (req_data),
        .ctrl     (ctrl),
        .count    (read_count),
        .found    (found[2])
    );

endmodule

/* tb/bpm_checker.sv */
// ----------------------------------------------------------------------------
// bpm_checker: response predictor and scoreboard for the breakpoint matcher
// Watches both channels of the matcher, keeps its own copy of the three
// breakpoint lists, their counts and the halted flag, and compares every
// response field by field with the prediction for the oldest open request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpm_checker #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  bpm_pkg::bpm_req_t req_data,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  bpm_pkg::bpm_rsp_t rsp_data,
    output int                fail_count,
    output int                pending
);
    import bpm_pkg::*;

    logic [23:0] code_list  [DEPTH];
    logic [23:0] write_list [DEPTH];
    logic [23:0] read_list  [DEPTH];
    int          code_active;
    int          write_active;
    int          read_active;
    bit          halted_now;
    bpm_rsp_t    awaited_q [$];

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        code_active  = 0;
        write_active = 0;
        read_active  = 0;
        halted_now   = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            code_list[i]  = '0;
            write_list[i] = '0;
            read_list[i]  = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic bit scan_hit(input logic [1:0] sel, input logic [23:0] addr);
        int n;
        int i;
        n = (sel == SEL_CODE) ? code_active : (sel == SEL_WRITE) ? write_active : read_active;
        for (i = 0; i < n; i++)
        begin
            if (sel == SEL_CODE && code_list[i] == addr)
                return 1'b1;
            if (sel == SEL_WRITE && write_list[i] == addr)
                return 1'b1;
            if (sel == SEL_READ && read_list[i] == addr)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one request to the shadow state and works out its response.
    task automatic predict_request(input bpm_req_t r, output bpm_rsp_t p);
        logic [1:0] kind;
        int         cnt;
        kind = KIND_NONE;
        cnt  = (r.entry_count > DEPTH) ? DEPTH : int'(r.entry_count);
        case (r.command)
            CMD_CHECK:
            begin
                // A halted unit does not scan at all.
                if (!halted_now)
                begin
                    if (scan_hit(SEL_CODE, r.program_counter))
                        kind = KIND_CODE;
                    else if (scan_hit(SEL_WRITE, r.last_write_address))
                        kind = KIND_WRITE;
                    else if (scan_hit(SEL_READ, r.last_read_address))
                        kind = KIND_READ;
                    if (kind != KIND_NONE)
                        halted_now = 1'b1;
                end
            end
            CMD_START, CMD_HALT:
                halted_now = 1'b1;
            CMD_STOP:
            begin
                halted_now   = 1'b0;
                code_active  = 0;
                write_active = 0;
                read_active  = 0;
            end
            CMD_RUN:
                halted_now = 1'b0;
            CMD_SET_COUNT:
            begin
                case (r.list_select)
                    SEL_CODE:  code_active  = cnt;
                    SEL_WRITE: write_active = cnt;
                    SEL_READ:  read_active  = cnt;
                    default: ;
                endcase
            end
            CMD_LOAD:
            begin
                if (r.entry_index < DEPTH)
                begin
                    case (r.list_select)
                        SEL_CODE:  code_list[r.entry_index]  = r.entry_address;
                        SEL_WRITE: write_list[r.entry_index] = r.entry_address;
                        SEL_READ:  read_list[r.entry_index]  = r.entry_address;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        p.debug_halted = halted_now;
        p.hit          = (kind != KIND_NONE);
        p.hit_kind     = kind;
    endtask

    always @(posedge clk)
    begin
        bpm_rsp_t want;
        if (!rst_n)
        begin
            code_active  = 0;
            write_active = 0;
            read_active  = 0;
            halted_now   = 1'b0;
            awaited_q.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_q.size() == 0)
                    report_mismatch($sformatf("response %h with no request waiting", rsp_data));
                else
                begin
                    want = awaited_q.pop_front();
                    if (rsp_data.debug_halted !== want.debug_halted)
                        report_mismatch($sformatf("debug_halted expected %0d got %0d",
                                                  want.debug_halted, rsp_data.debug_halted));
                    if (rsp_data.hit !== want.hit)
                        report_mismatch($sformatf("hit expected %0d got %0d",
                                                  want.hit, rsp_data.hit));
                    if (rsp_data.hit_kind !== want.hit_kind)
                        report_mismatch($sformatf("hit_kind expected %0d got %0d",
                                                  want.hit_kind, rsp_data.hit_kind));
                end
            end
            if (req_valid && req_ready)
            begin
                predict_request(req_data, want);
                awaited_q.push_back(want);
            end
        end
        pending = awaited_q.size();
    end

endmodule

/* tb/tb_debug_breakpoint_matcher_core.sv */
// ----------------------------------------------------------------------------
// tb_debug_breakpoint_matcher_core: stimulus and verdict for the matcher
// Drives a directed set of requests followed by a preload of every list entry
// and a long random mix of checks and commands, with random idling on both
// channels; the checker alongside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_debug_breakpoint_matcher_core;
    import bpm_pkg::*;

    localparam int         DEPTH          = 64;
    localparam int         POOL_SIZE      = 8;
    localparam int         RANDOM_ITEMS   = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] CMD_UNUSED     = 3'd7;
    localparam logic [1:0] SEL_UNUSED     = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    bpm_req_t    req_data  = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    bpm_rsp_t    rsp_data;
    int          fail_count;
    int          pending;
    bit          calm      = 1'b0;
    int          quiet_cycles = 0;
    logic [23:0] addr_pool [POOL_SIZE];

    debug_breakpoint_matcher_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    bpm_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        rsp_ready <= calm || ($urandom_range(0, 99) >= 25);

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Mostly addresses from a small pool, so that breakpoints actually hit.
    function automatic logic [23:0] pick_addr();
        logic [31:0] raw;
        raw = $urandom();
        if ($urandom_range(0, 99) < 80)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return raw[23:0];
    endfunction

    function automatic logic [15:0] pick_count();
        logic [31:0] raw;
        int          roll;
        raw  = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 16'($urandom_range(0, 8));
        if (roll < 85)
            return 16'($urandom_range(9, DEPTH));
        return raw[15:0];
    endfunction

    function automatic logic [1:0] pick_list();
        if ($urandom_range(0, 9) == 0)
            return SEL_UNUSED;
        return 2'($urandom_range(0, 2));
    endfunction

    function automatic bpm_req_t noisy_request();
        bpm_req_t    r;
        logic [31:0] raw;
        raw                  = $urandom();
        r.command            = 3'($urandom_range(0, 7));
        r.list_select        = 2'($urandom_range(0, 3));
        r.entry_index        = 6'($urandom_range(0, DEPTH - 1));
        r.entry_count        = raw[15:0];
        r.entry_address      = pick_addr();
        r.program_counter    = pick_addr();
        r.last_write_address = pick_addr();
        r.last_read_address  = pick_addr();
        return r;
    endfunction

    function automatic bpm_req_t make_req(input logic [2:0] cmd, input logic [1:0] sel,
                                          input logic [5:0] idx, input logic [15:0] cnt,
                                          input logic [23:0] addr, input logic [23:0] pc,
                                          input logic [23:0] wr, input logic [23:0] rd);
        bpm_req_t r;
        r.command            = cmd;
        r.list_select        = sel;
        r.entry_index        = idx;
        r.entry_count        = cnt;
        r.entry_address      = addr;
        r.program_counter    = pc;
        r.last_write_address = wr;
        r.last_read_address  = rd;
        return r;
    endfunction

    // Entered and left at a falling edge; valid is only lowered for idle cycles.
    task automatic send_request(input bpm_req_t r);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 25)
            begin
                req_valid <= 1'b0;
                @(negedge clk);
            end
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        bpm_req_t r;
        int       roll;
        addr_pool[0] = 24'h000000;
        addr_pool[1] = 24'hFFFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = 24'($urandom());

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: only entries that are loaded are ever made active.
        send_request(make_req(CMD_CHECK, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_request(make_req(CMD_LOAD, SEL_CODE, 6'd0, 16'hFFFF, 24'h000000,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_LOAD, SEL_CODE, 6'd63, 16'd0, 24'hFFFFFF,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_LOAD, SEL_WRITE, 6'd0, 16'd0, 24'h123456,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_LOAD, SEL_READ, 6'd0, 16'd0, 24'hFFFFFF,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_LOAD, SEL_UNUSED, 6'd5, 16'd0, 24'hABCDEF,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_SET_COUNT, SEL_CODE, 6'd0, 16'd1, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_SET_COUNT, SEL_WRITE, 6'd0, 16'd1, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_SET_COUNT, SEL_READ, 6'd0, 16'd1, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_SET_COUNT, SEL_UNUSED, 6'd0, 16'hFFFF, 24'h0,
                              24'h0, 24'h0, 24'h0));
        // Code, write and read all match here; the code hit must win.
        send_request(make_req(CMD_CHECK, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h000000, 24'h123456, 24'hFFFFFF));
        send_request(make_req(CMD_CHECK, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h000000, 24'h123456, 24'hFFFFFF));
        send_request(make_req(CMD_RUN, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_CHECK, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h000001, 24'h123456, 24'h000000));
        send_request(make_req(CMD_RUN, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_CHECK, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h000001, 24'h000000, 24'hFFFFFF));
        send_request(make_req(CMD_RUN, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_CHECK, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'hFFFFFF, 24'hFFFFFF, 24'h000000));
        send_request(make_req(CMD_START, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_UNUSED, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_RUN, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_HALT, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_STOP, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h0, 24'h0, 24'h0));
        send_request(make_req(CMD_CHECK, SEL_CODE, 6'd0, 16'd0, 24'h0,
                              24'h000000, 24'h123456, 24'hFFFFFF));

        // Fill every entry of every list so that any count is safe to scan.
        for (int sel = 0; sel < 3; sel++)
        begin
            for (int idx = 0; idx < DEPTH; idx++)
            begin
                r               = noisy_request();
                r.command       = CMD_LOAD;
                r.list_select   = 2'(sel);
                r.entry_index   = 6'(idx);
                r.entry_address = pick_addr();
                send_request(r);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm <= (n >= 100 && n < 180);
            r    = noisy_request();
            roll = $urandom_range(0, 99);
            if (roll < 45)
                r.command = CMD_CHECK;
            else if (roll < 60)
                r.command = CMD_RUN;
            else if (roll < 63)
                r.command = CMD_START;
            else if (roll < 66)
                r.command = CMD_HALT;
            else if (roll < 70)
                r.command = CMD_STOP;
            else if (roll < 84)
            begin
                r.command     = CMD_SET_COUNT;
                r.list_select = pick_list();
                r.entry_count = pick_count();
            end
            else if (roll < 97)
            begin
                r.command     = CMD_LOAD;
                r.list_select = pick_list();
            end
            else
                r.command = CMD_UNUSED;
            send_request(r);
        end

        calm      <= 1'b0;
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
